// ===== rtl/assert_macros.svh =====
// Assertion macros used by the octave value noise datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OVN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OVN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ovn_pkg.sv =====
// Types and constants of the octave value noise unit.
package ovn_pkg;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] MODE_SMOOTH = 2'd0;
	localparam logic [1:0] MODE_CUBIC  = 2'd1;
	localparam logic [1:0] MODE_LINEAR = 2'd2;

	localparam int APB_AW = 5;
	localparam logic [2:0] REG_OCTAVE_COUNT = 3'd0;
	localparam logic [2:0] REG_INTERP_MODE  = 3'd1;
	localparam logic [2:0] REG_LOG2_WL      = 3'd2;
	localparam logic [2:0] REG_HEIGHT_GAIN  = 3'd3;
	localparam logic [2:0] REG_OFFSET_VALUE = 3'd4;

	// Height divisor is 1000 * 2^26; these split it into a shift and a divide by 1000.
	localparam logic [45:0] HALF_D  = 46'd33554432000;
	localparam logic [40:0] RECIP_M = 41'd1073741;
	localparam logic [19:0] DIV_K   = 20'd1000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_RD1, ST_RD2, ST_WEIGHT, ST_BLEND, ST_ACCUM,
		ST_FIN1, ST_FIN2, ST_FIN3, ST_FIN4, ST_EMIT
	} ovn_state_t;

	typedef enum logic [3:0] {
		CMD_NOP, CMD_LOAD, CMD_START, CMD_SETUP, CMD_RD1, CMD_RD2, CMD_WEIGHT,
		CMD_BLEND, CMD_ACCUM, CMD_FIN1, CMD_FIN2, CMD_FIN3, CMD_FIN4, CMD_EMIT
	} ovn_op_t;

	typedef struct packed {
		ovn_op_t op;
	} ovn_cmd_t;

	typedef struct packed {
		logic done;
		logic skip;
		logic out_busy;
	} ovn_sts_t;

	typedef struct packed {
		logic [3:0]        octave_count;
		logic [1:0]        interp_mode;
		logic [3:0]        log2_wl;
		logic [15:0]       height_gain;
		logic signed [15:0] offset_value;
	} ovn_cfg_t;

endpackage

// ===== rtl/ovn_if.sv =====
// Query/load channel and height result channel.
interface ovn_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [10:0] value_index;
	logic [9:0] lattice_value;
	logic [9:0] position;
	modport source (output valid, kind, value_index, lattice_value, position, input ready);
	modport sink (input valid, kind, value_index, lattice_value, position, output ready);
endinterface

interface ovn_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] height_value;
	modport source (output valid, height_value, input ready);
	modport sink (input valid, height_value, output ready);
endinterface

// ===== rtl/octave_value_noise_1d_unit.sv =====
// Octave value noise unit: one octave-summed terrain height per query beat.
// A load beat writes the lattice table; it gives no result.
// Per active octave a query runs setup, two table reads, weight, blend and accumulate;
// an octave past the lattice goes from setup straight to accumulate. The scaling steps and
// the emit step follow; emit waits while the last height is untaken. Beats enter only in idle.
// Reset restores the register defaults and idles the sequencer; table contents stay undefined.
module octave_value_noise_1d_unit #(
	parameter int SAMPLES     = 1024,
	parameter int VALUE_DEPTH = 2048,
	parameter int MAX_OCTAVES = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ovn_req_if.sink                    req,
	ovn_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ovn_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ovn_pkg::*;

	ovn_cfg_t cfg;
	ovn_cmd_t cmd;
	ovn_sts_t sts;

	ovn_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	ovn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_kind(req.kind),
		.req_ready(req.ready), .sts(sts), .cmd(cmd)
	);

	ovn_dp #(
		.SAMPLES(SAMPLES), .VALUE_DEPTH(VALUE_DEPTH), .MAX_OCTAVES(MAX_OCTAVES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd),
		.value_index(req.value_index), .lattice_value(req.lattice_value),
		.position(req.position), .out_ready(rsp.ready), .out_valid(rsp.valid),
		.height_value(rsp.height_value), .sts(sts)
	);
endmodule

// ===== rtl/ovn_cfg.sv =====
// APB configuration registers.
module ovn_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ovn_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ovn_pkg::ovn_cfg_t          cfg
);
	import ovn_pkg::*;

	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.octave_count <= 4'd1;
			cfg.interp_mode  <= MODE_SMOOTH;
			cfg.log2_wl      <= 4'd10;
			cfg.height_gain  <= 16'd256;
			cfg.offset_value <= 16'sd0;
		end else if (wr) begin
			unique case (idx)
				REG_OCTAVE_COUNT: cfg.octave_count <= pwdata[3:0];
				REG_INTERP_MODE:  cfg.interp_mode <= pwdata[1:0];
				REG_LOG2_WL:      cfg.log2_wl <= pwdata[3:0];
				REG_HEIGHT_GAIN:  cfg.height_gain <= pwdata[15:0];
				REG_OFFSET_VALUE: cfg.offset_value <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OCTAVE_COUNT: prdata = 32'(cfg.octave_count);
			REG_INTERP_MODE:  prdata = 32'(cfg.interp_mode);
			REG_LOG2_WL:      prdata = 32'(cfg.log2_wl);
			REG_HEIGHT_GAIN:  prdata = 32'(cfg.height_gain);
			REG_OFFSET_VALUE: prdata = {16'h0000, cfg.offset_value};
			default:          prdata = 32'h0000_0000;
		endcase
	end
endmodule

// ===== rtl/ovn_ctrl.sv =====
// Sequencer that walks a query through its octaves and the final scaling.
module ovn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_kind,
	output logic              req_ready,
	input  ovn_pkg::ovn_sts_t sts,
	output ovn_pkg::ovn_cmd_t cmd
);
	import ovn_pkg::*;

	ovn_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid && req_kind == KIND_QUERY) state_nxt = ST_SETUP;
			ST_SETUP: begin
				if (sts.done) state_nxt = ST_FIN1;
				else if (sts.skip) state_nxt = ST_ACCUM;
				else state_nxt = ST_RD1;
			end
			ST_RD1:    state_nxt = ST_RD2;
			ST_RD2:    state_nxt = ST_WEIGHT;
			ST_WEIGHT: state_nxt = ST_BLEND;
			ST_BLEND:  state_nxt = ST_ACCUM;
			ST_ACCUM:  state_nxt = ST_SETUP;
			ST_FIN1:   state_nxt = ST_FIN2;
			ST_FIN2:   state_nxt = ST_FIN3;
			ST_FIN3:   state_nxt = ST_FIN4;
			ST_FIN4:   state_nxt = ST_EMIT;
			ST_EMIT:   if (!sts.out_busy) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd.op = CMD_NOP;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd.op = (req_kind == KIND_QUERY) ? CMD_START : CMD_LOAD;
			end
			ST_SETUP:  cmd.op = CMD_SETUP;
			ST_RD1:    cmd.op = CMD_RD1;
			ST_RD2:    cmd.op = CMD_RD2;
			ST_WEIGHT: cmd.op = CMD_WEIGHT;
			ST_BLEND:  cmd.op = CMD_BLEND;
			ST_ACCUM:  cmd.op = CMD_ACCUM;
			ST_FIN1:   cmd.op = CMD_FIN1;
			ST_FIN2:   cmd.op = CMD_FIN2;
			ST_FIN3:   cmd.op = CMD_FIN3;
			ST_FIN4:   cmd.op = CMD_FIN4;
			ST_EMIT:   if (!sts.out_busy) cmd.op = CMD_EMIT;
			default:   cmd.op = CMD_NOP;
		endcase
	end
endmodule

// ===== rtl/ovn_dp.sv =====
// Datapath: lattice table, weight multipliers, octave accumulator and output scaling.
module ovn_dp #(
	parameter int SAMPLES     = 1024,
	parameter int VALUE_DEPTH = 2048,
	parameter int MAX_OCTAVES = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ovn_pkg::ovn_cfg_t  cfg,
	input  ovn_pkg::ovn_cmd_t  cmd,
	input  logic [10:0]        value_index,
	input  logic [9:0]         lattice_value,
	input  logic [9:0]         position,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [15:0] height_value,
	output ovn_pkg::ovn_sts_t  sts
);
	import ovn_pkg::*;
	`include "assert_macros.svh"

	localparam int AW  = $clog2(VALUE_DEPTH);
	localparam int IW0 = $clog2(SAMPLES) + MAX_OCTAVES + 1;
	localparam int IW  = (IW0 > 11) ? IW0 : 11;
	localparam int RW  = (IW > AW + 1) ? IW : AW + 1;
	localparam int XW  = (AW > 11) ? AW + 1 : 12;

	logic [9:0] mem [VALUE_DEPTH];

	logic [9:0]    pos_q;
	logic [4:0]    n_q, oct_q;
	logic [IW-1:0] npts_q, start_q, addr1_q, addr2_q;
	logic          in1_q, in2_q, skip_q, up_q;
	logic [15:0]   a_q;
	logic [16:0]   m_q, f_q;
	logic [33:0]   p1_q;
	logic [50:0]   p2_q;
	logic [9:0]    rd_data_q, y1_q, y2_q;
	logic [25:0]   v_q;
	logic [26:0]   acc_q;
	logic [44:0]   prod_q;
	logic [19:0]   y_q;
	logic          r26nz_q, rnz_q, out_valid_q;
	logic [10:0]   q0_q, q_q;
	logic signed [15:0] height_q;

	// Octave setup.
	logic [3:0]    s;
	logic [9:0]    seg;
	logic [IW-1:0] seg_w, prev_addr, cur_addr;
	logic [RW-1:0] prev_ext, cur_ext, rd_ext;
	logic [15:0]   frac, a_new;
	logic [4:0]    lw1, oc5, mo5, n_new;
	logic          skip_c;

	always_comb begin
		s = cfg.log2_wl - oct_q[3:0];
		seg = pos_q >> s;
		seg_w = IW'(seg);
		skip_c = seg_w >= npts_q;
		prev_addr = (seg == 10'd0) ? start_q + npts_q - IW'(1) : start_q + seg_w - IW'(1);
		cur_addr = start_q + seg_w;
		prev_ext = RW'(prev_addr);
		cur_ext = RW'(cur_addr);
		frac = 16'(pos_q) & ((16'd1 << s) - 16'd1);
		a_new = frac << (5'd16 - {1'b0, s});
		lw1 = {1'b0, cfg.log2_wl} + 5'd1;
		oc5 = {1'b0, cfg.octave_count};
		mo5 = 5'(MAX_OCTAVES);
		n_new = oc5;
		if (lw1 < n_new) n_new = lw1;
		if (mo5 < n_new) n_new = mo5;
	end

	// Table access: one write port for loads, one registered read port.
	logic          wr_en, rd_en;
	logic [XW-1:0] wr_ext;
	logic [AW-1:0] wr_addr, rd_addr;

	assign wr_ext = XW'(value_index);
	assign wr_addr = wr_ext[AW-1:0];
	assign wr_en = (cmd.op == CMD_LOAD) && (wr_ext < XW'(VALUE_DEPTH));
	assign rd_en = (cmd.op == CMD_RD1) || (cmd.op == CMD_RD2);
	assign rd_ext = RW'((cmd.op == CMD_RD1) ? addr1_q : addr2_q);
	assign rd_addr = rd_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= lattice_value;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// Weight multiplier operands.
	logic [16:0] a2, m_new, mul1_a, mul1_b;
	logic [32:0] mul2_a;
	logic [17:0] mul2_b;
	logic [50:0] smooth_sum, cubic_num, cubic_sum;
	logic [16:0] f_new;

	always_comb begin
		a2 = {a_q, 1'b0};
		m_new = a_q[15] ? a2 - 17'h10000 : 17'h10000 - a2;
		mul1_a = {1'b0, a_q};
		mul1_b = {1'b0, a_q};
		mul2_a = 33'(p1_q[31:0]);
		mul2_b = 18'd196608 - 18'(a2);
		if (cfg.interp_mode == MODE_CUBIC) begin
			mul1_a = m_new;
			mul1_b = m_new;
			mul2_a = p1_q[32:0];
			mul2_b = 18'(m_q);
		end
		smooth_sum = p2_q + 51'h0_0000_8000_0000;
		cubic_num = up_q ? 51'h1_0000_0000_0000 + p2_q : 51'h1_0000_0000_0000 - p2_q;
		cubic_sum = cubic_num + 51'h0_0001_0000_0000;
		case (cfg.interp_mode)
			MODE_SMOOTH: f_new = smooth_sum[48:32];
			MODE_CUBIC:  f_new = cubic_sum[49:33];
			default:     f_new = {1'b0, a_q};
		endcase
	end

	// Blend, accumulate and final scaling.
	logic signed [10:0] diff;
	logic signed [28:0] blend_prod;
	logic [29:0]        v_full;
	logic [26:0]        acc_add;
	logic [28:0]        acc3;
	logic [45:0]        xsum;
	logic [40:0]        qm;
	logic [19:0]        rem;
	logic signed [17:0] hsum;
	logic signed [15:0] h_new;

	always_comb begin
		diff = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
		blend_prod = $signed({1'b0, f_q}) * diff;
		v_full = {4'b0000, y1_q, 16'h0000} + {blend_prod[28], blend_prod};
		acc_add = 27'(v_q >> {oct_q, 1'b0});
		acc3 = {2'b00, acc_q} + {1'b0, acc_q, 1'b0};
		xsum = {1'b0, prod_q} + HALF_D;
		qm = 41'(y_q) * RECIP_M;
		rem = y_q - 20'(q0_q) * DIV_K;
		// Truncation toward zero: a negative sum of quotient and offset with a remainder moves up by one.
		hsum = $signed({7'b0000000, q_q}) + $signed({{2{cfg.offset_value[15]}}, cfg.offset_value});
		if (hsum < 0 && rnz_q) hsum = hsum + 18'sd1;
		if (hsum > 18'sd32767) h_new = 16'sh7fff;
		else if (hsum < -18'sd32768) h_new = -16'sh8000;
		else h_new = hsum[15:0];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_START: begin
				pos_q <= position;
				n_q <= n_new;
				oct_q <= 5'd0;
				npts_q <= IW'(SAMPLES) >> cfg.log2_wl;
				start_q <= '0;
				acc_q <= '0;
			end
			CMD_SETUP: begin
				skip_q <= skip_c;
				a_q <= a_new;
				addr1_q <= prev_addr;
				addr2_q <= cur_addr;
				in1_q <= prev_ext < RW'(VALUE_DEPTH);
				in2_q <= cur_ext < RW'(VALUE_DEPTH);
			end
			CMD_RD1: begin
				m_q <= m_new;
				up_q <= a_q[15];
				p1_q <= 34'(mul1_a) * 34'(mul1_b);
			end
			CMD_RD2: begin
				y1_q <= in1_q ? rd_data_q : 10'd0;
				p2_q <= 51'(mul2_a) * 51'(mul2_b);
			end
			CMD_WEIGHT: begin
				y2_q <= in2_q ? rd_data_q : 10'd0;
				f_q <= f_new;
			end
			CMD_BLEND: v_q <= v_full[25:0];
			CMD_ACCUM: begin
				if (!skip_q) acc_q <= acc_q + acc_add;
				oct_q <= oct_q + 5'd1;
				start_q <= start_q + npts_q;
				npts_q <= npts_q << 1;
			end
			CMD_FIN1: prod_q <= 45'(acc3) * 45'(cfg.height_gain);
			CMD_FIN2: begin
				y_q <= xsum[45:26];
				r26nz_q <= |xsum[25:0];
			end
			CMD_FIN3: q0_q <= qm[40:30];
			CMD_FIN4: begin
				if (rem >= DIV_K) begin
					q_q <= q0_q + 11'd1;
					rnz_q <= (rem != DIV_K) || r26nz_q;
				end else begin
					q_q <= q0_q;
					rnz_q <= (rem != 20'd0) || r26nz_q;
				end
			end
			CMD_EMIT: height_q <= h_new;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == CMD_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign height_value = height_q;
	assign sts.done = oct_q >= n_q;
	assign sts.skip = skip_c;
	assign sts.out_busy = out_valid_q && !out_ready;

	`OVN_ASSERT_NEXT(a_acc_grows, cmd.op == CMD_ACCUM, acc_q >= $past(acc_q))
	`OVN_ASSERT_NEXT(a_weight_range, cmd.op == CMD_WEIGHT, f_q <= 17'h10000)
	`OVN_ASSERT_IMP(a_blend_nonneg, cmd.op == CMD_BLEND, !v_full[29])
endmodule
